FILE: design/assert_macros.svh
// Assertion macros shared by the gcd and lcm unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge while reset is low.
`define GCL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define GCL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GCL_ASSERT(label, clk, rst, prop, msg)
`define GCL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: design/gcl_pkg.sv
// Types and constants of the gcd and lcm unit.
package gcl_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int MULT_WIDTH        = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL
  } core_state_t;

  typedef enum logic [1:0] {
    GS_IDLE,
    GS_REDUCE,
    GS_SCALE
  } gcd_state_t;

endpackage

FILE: design/gcd_lcm_unit_core.sv
// Top level of the gcd and lcm unit: sequencer over gcd, divide and multiply.
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  -----------------------------
//  command   operand_a, operand_b                   start high while busy is low
//  result    divisor, multiple, zero_error          done high for one cycle
//
// A zero operand answers on the cycle after the command. Otherwise the gcd runs first
// (one reduction step a cycle, then a serial shift for the common power of two), then
// lcm = (a / gcd) * b is formed in the divider and then in the multiplier, and the done
// strobe is registered from the multiplier's done.
// One word is in flight at a time; busy covers it. Reset clears the sequencer and strobe.
`include "assert_macros.svh"
module gcd_lcm_unit_core #(
  parameter int OPERAND_WIDTH = gcl_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [gcl_pkg::FIELD_WIDTH-1:0] operand_a,
  input  logic [gcl_pkg::FIELD_WIDTH-1:0] operand_b,
  output logic                            busy,
  output logic                            done,
  output logic [gcl_pkg::FIELD_WIDTH-1:0] divisor,
  output logic [gcl_pkg::MULT_WIDTH-1:0]  multiple,
  output logic                            zero_error
);
  import gcl_pkg::*;

  localparam int W = OPERAND_WIDTH;

  core_state_t    state, state_next;
  logic [W-1:0]   a_m, b_m, a_reg, b_reg, g_reg;
  logic [W-1:0]   gcd_res, quot;
  logic [2*W-1:0] prod;
  logic           accept, has_zero;
  logic           gcd_start, div_start, mul_start;
  logic           gcd_done, div_done, mul_done;

  assign a_m      = operand_a[W-1:0];
  assign b_m      = operand_b[W-1:0];
  assign has_zero = (a_m == '0) || (b_m == '0);
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;

  gcl_gcd #(.W(W)) u_gcd (
    .clk    (clk),
    .rst    (rst),
    .start  (gcd_start),
    .a      (a_m),
    .b      (b_m),
    .done   (gcd_done),
    .result (gcd_res)
  );

  gcl_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a_reg),
    .dsr_in   (gcd_res),
    .done     (div_done),
    .quotient (quot)
  );

  gcl_mul #(.W(W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (b_reg),
    .mplier  (quot),
    .done    (mul_done),
    .product (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (accept && has_zero) || mul_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_reg <= a_m;
      b_reg <= b_m;
    end
    if (gcd_done) begin
      g_reg <= gcd_res;
    end
    if (accept && has_zero) begin
      divisor    <= '0;
      multiple   <= '0;
      zero_error <= 1'b1;
    end else if (mul_done) begin
      divisor    <= FIELD_WIDTH'(g_reg);
      multiple   <= MULT_WIDTH'(prod);
      zero_error <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    gcd_start  = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && !has_zero) begin
          gcd_start  = 1'b1;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `GCL_ASSERT(a_zero_clears, clk, rst, (done && zero_error) |-> (divisor == '0 && multiple == '0), "zero operand result not cleared")
  `GCL_ASSERT(a_gcd_nonzero, clk, rst, (done && !zero_error) |-> (divisor != '0), "gcd of nonzero operands is zero")
  `GCL_ASSERT(a_lcm_ge_gcd, clk, rst, (done && !zero_error) |-> (multiple >= MULT_WIDTH'(divisor)), "lcm below gcd")
  `GCL_ASSERT(a_accept_busy, clk, rst, (accept && !has_zero) |=> busy, "nonzero command did not raise busy")
  `GCL_ASSERT_ALWAYS(a_gcd_in_phase, clk, gcd_done |-> (rst || state == ST_GCD), "gcd finished outside its phase")

endmodule

FILE: design/gcl_gcd.sv
// Binary gcd: one reduction step per cycle, then a serial scale by the common power of two.
module gcl_gcd #(
  parameter int W = gcl_pkg::OPERAND_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] result
);
  import gcl_pkg::*;

  localparam int KW = $clog2(W);

  gcd_state_t    state, state_next;
  logic [W-1:0]  u, u_next, v, v_next, diff;
  logic [KW-1:0] k, k_next;
  logic          done_next, u_ge;

  assign u_ge   = (u >= v);
  assign diff   = u_ge ? (u - v) : (v - u);
  assign result = u;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    u <= u_next;
    v <= v_next;
    k <= k_next;
  end

  always_comb begin
    state_next = state;
    u_next     = u;
    v_next     = v;
    k_next     = k;
    done_next  = 1'b0;
    case (state)
      GS_IDLE: begin
        if (start) begin
          u_next     = a;
          v_next     = b;
          k_next     = '0;
          state_next = GS_REDUCE;
        end
      end
      GS_REDUCE: begin
        if (u == '0) begin
          u_next     = v;
          state_next = GS_SCALE;
        end else if (v == '0) begin
          state_next = GS_SCALE;
        end else if (!u[0] && !v[0]) begin
          // common factor of two: count it, restore it at the end
          u_next = u >> 1;
          v_next = v >> 1;
          k_next = k + KW'(1);
        end else if (!u[0]) begin
          u_next = u >> 1;
        end else if (!v[0]) begin
          v_next = v >> 1;
        end else if (u_ge) begin
          // both odd: the difference is even, halve it at once
          u_next = diff >> 1;
        end else begin
          v_next = diff >> 1;
        end
      end
      GS_SCALE: begin
        if (k == '0) begin
          done_next  = 1'b1;
          state_next = GS_IDLE;
        end else begin
          u_next = u << 1;
          k_next = k - KW'(1);
        end
      end
      default: state_next = GS_IDLE;
    endcase
  end

endmodule

FILE: design/gcl_div.sv
// Restoring divider: one quotient bit per cycle.
module gcl_div #(
  parameter int W = gcl_pkg::OPERAND_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] dsr_in,
  output logic         done,
  output logic [W-1:0] quotient
);
  import gcl_pkg::*;

  localparam int CW = $clog2(W);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem, dvd, dsr;
  logic [W:0]    trial, diff;
  logic          fits;

  assign trial    = {rem, dvd[W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign fits     = (trial >= {1'b0, dsr});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(W - 1);
      rem <= '0;
      dvd <= dividend;
      dsr <= dsr_in;
    end else if (run) begin
      cnt <= cnt - CW'(1);
      // shift the next dividend bit into the remainder, the quotient bit in at the bottom
      rem <= fits ? diff[W-1:0] : trial[W-1:0];
      dvd <= {dvd[W-2:0], fits};
    end
  end

endmodule

FILE: design/gcl_mul.sv
// Shift-add multiplier: one multiplier bit per cycle.
module gcl_mul #(
  parameter int W = gcl_pkg::OPERAND_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic           done,
  output logic [2*W-1:0] product
);
  import gcl_pkg::*;

  localparam int CW = $clog2(W);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  hi, lo, mc;
  logic [W:0]    sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, mc} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(W - 1);
      hi  <= '0;
      lo  <= mplier;
      mc  <= mcand;
    end else if (run) begin
      cnt <= cnt - CW'(1);
      // shift the partial sum down, low bit drops into the product's low half
      hi  <= sum[W:1];
      lo  <= {sum[0], lo[W-1:1]};
    end
  end

endmodule
